@@ sv/rwew_pkg.sv @@
package rwew_pkg;

  // field widths
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FLAG_W   = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CFG  = 8;

  // parameter defaults
  localparam int unsigned WATCH_SLOTS_DEF      = 15;
  localparam int unsigned INIT_FLAG_BIT_DEF    = 15;
  localparam int unsigned DEFAULT_DEV_ADDR_DEF = 32;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_IDX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_IDX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RST_IDX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RST_CODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ERS_CODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CODE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_MIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_MAX  = 3'd7;

  function automatic logic [BYTE_W-1:0] cfg_reset_val(input logic [CFG_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] v;
    case (idx)
      CFG_CMD_IDX:   v = 8'd78;
      CFG_ADDR_IDX:  v = 8'd77;
      CFG_RST_IDX:   v = 8'd88;
      CFG_RST_CODE:  v = 8'd202;
      CFG_ERS_CODE:  v = 8'd69;
      CFG_INIT_CODE: v = 8'd73;
      CFG_ADDR_MIN:  v = 8'd8;
      CFG_ADDR_MAX:  v = 8'd119;
      default:       v = 8'd0;
    endcase
    return v;
  endfunction

  // watch table request and response
  typedef struct packed {
    logic              start;
    logic              add;
    logic [BYTE_W-1:0] key;
  } scan_req_t;

  typedef struct packed {
    logic              done;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } scan_rsp_t;

endpackage

@@ sv/rwew_watch.sv @@
module rwew_watch
  import rwew_pkg::*;
#(
  parameter int unsigned WATCH_SLOTS = WATCH_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_req_t req,
  output scan_rsp_t rsp
);

  localparam int unsigned IDX_W = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WATCH_SLOTS - 1);

  logic [BYTE_W-1:0] table_r [WATCH_SLOTS];
  logic              busy_r, busy_nxt;
  logic              add_r, add_nxt;
  logic [BYTE_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] entry;
  logic              free;
  logic              match;
  logic              wr_en;

  assign entry = table_r[cnt_r];
  assign free  = (entry == '0);
  assign match = (entry == key_r);

  always_comb begin
    busy_nxt = busy_r;
    add_nxt  = add_r;
    key_nxt  = key_r;
    cnt_nxt  = cnt_r;
    wr_en    = 1'b0;
    rsp      = '0;
    rsp.slot = SLOT_W'(cnt_r);
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        add_nxt  = req.add;
        key_nxt  = req.key;
        cnt_nxt  = '0;
      end
    end else begin
      // walk stops at the first free slot, at a match on a lookup, or at the end
      if (free) begin
        wr_en    = add_r;
        rsp.done = 1'b1;
        busy_nxt = 1'b0;
      end else if (!add_r && match) begin
        rsp.hit  = 1'b1;
        rsp.done = 1'b1;
        busy_nxt = 1'b0;
      end else if (cnt_r == LAST_IDX) begin
        rsp.done = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      add_r  <= 1'b0;
      key_r  <= '0;
      cnt_r  <= '0;
      for (int i = 0; i < WATCH_SLOTS; i++) begin
        table_r[i] <= '0;
      end
    end else begin
      busy_r <= busy_nxt;
      add_r  <= add_nxt;
      key_r  <= key_nxt;
      cnt_r  <= cnt_nxt;
      if (wr_en) begin
        table_r[cnt_r] <= key_r;
      end
    end
  end

endmodule

@@ sv/register_write_event_watcher.sv @@
// register write event watcher
//
// input channel (in_valid / in_stall): one item per finished register write,
// carrying kind, register index and the byte written. kind write decodes
// command, address and reset registers, or looks the index up in the watch
// table; kind add stores a register in the first free watch slot; kind clear
// returns the flag word and zeroes it. one result item comes out per item.
// in_stall is high whenever an item is in flight: one item at a time.
// sequence: the accepted item is latched, decoded in the execute state, and
// its result loaded into the result register, raising out_valid, for command,
// address, reset, clear and no-op items; a table walk first passes through
// the scan state, the single slot comparator stepping one slot per cycle.
// after the result is taken the block returns to idle before the next item
// is accepted. out_valid holds with a steady payload while out_stall is high;
// soft reset and flash erase hold until the next item executes and change no
// state here. config port (cfg_valid / cfg_ready / cfg_index / cfg_data) is
// always ready; the user must see that it is written only while idle, the
// block does not enforce this. synchronous reset clears the watch table and
// flags, loads the default slave address and the register defaults.
module register_write_event_watcher
  import rwew_pkg::*;
#(
  parameter int unsigned WATCH_SLOTS      = WATCH_SLOTS_DEF,
  parameter int unsigned INIT_FLAG_BIT    = INIT_FLAG_BIT_DEF,
  parameter int unsigned DEFAULT_DEV_ADDR = DEFAULT_DEV_ADDR_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // item input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [BYTE_W-1:0]    in_reg_index,
  input  logic [BYTE_W-1:0]    in_written_value,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FLAG_W-1:0]    out_flag_word,
  output logic [BYTE_W-1:0]    out_dev_addr,
  output logic                 out_soft_reset,
  output logic                 out_flash_erase,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [FLAG_W-1:0] INIT_MASK = FLAG_W'(1) << INIT_FLAG_BIT;

  logic [1:0]        state_r, state_nxt;
  logic [BYTE_W-1:0] cfg_r [NUM_CFG];

  // latched item
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [BYTE_W-1:0] reg_r, reg_nxt;
  logic [BYTE_W-1:0] val_r, val_nxt;

  // block state
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic [BYTE_W-1:0] addr_r, addr_nxt;

  // result register
  logic [FLAG_W-1:0] out_flags_r, out_flags_nxt;
  logic [BYTE_W-1:0] out_addr_r, out_addr_nxt;
  logic              out_rst_r, out_rst_nxt;
  logic              out_ers_r, out_ers_nxt;

  scan_req_t scan_req;
  scan_rsp_t scan_rsp;

  rwew_watch #(
    .WATCH_SLOTS(WATCH_SLOTS)
  ) u_watch (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (scan_req),
    .rsp  (scan_rsp)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign cfg_ready       = 1'b1;
  assign out_flag_word   = out_flags_r;
  assign out_dev_addr    = out_addr_r;
  assign out_soft_reset  = out_rst_r;
  assign out_flash_erase = out_ers_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    reg_nxt       = reg_r;
    val_nxt       = val_r;
    flags_nxt     = flags_r;
    addr_nxt      = addr_r;
    out_flags_nxt = out_flags_r;
    out_addr_nxt  = out_addr_r;
    out_rst_nxt   = out_rst_r;
    out_ers_nxt   = out_ers_r;
    scan_req      = '0;
    scan_req.key  = reg_r;
    scan_req.add  = (kind_r == KIND_ADD);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          reg_nxt   = in_reg_index;
          val_nxt   = in_written_value;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        out_rst_nxt = 1'b0;
        out_ers_nxt = 1'b0;
        state_nxt   = ST_OUT;
        case (kind_r)
          KIND_WRITE: begin
            // command register wins over address register, then reset register
            if (reg_r == cfg_r[CFG_CMD_IDX]) begin
              if (val_r == cfg_r[CFG_RST_CODE]) begin
                out_rst_nxt = 1'b1;
              end else if (val_r == cfg_r[CFG_ERS_CODE]) begin
                out_ers_nxt = 1'b1;
              end else if (val_r == cfg_r[CFG_INIT_CODE]) begin
                flags_nxt = flags_r | INIT_MASK;
              end
            end else if (reg_r == cfg_r[CFG_ADDR_IDX]) begin
              if (val_r >= cfg_r[CFG_ADDR_MIN] && val_r <= cfg_r[CFG_ADDR_MAX]) begin
                addr_nxt = val_r;
              end
            end else if (reg_r == cfg_r[CFG_RST_IDX]) begin
              out_rst_nxt = 1'b1;
            end else begin
              scan_req.start = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end
          KIND_ADD: begin
            scan_req.start = 1'b1;
            state_nxt      = ST_SCAN;
          end
          KIND_CLEAR: begin
            flags_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          if (scan_rsp.hit) begin
            flags_nxt = flags_r | (FLAG_W'(1) << scan_rsp.slot);
          end
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // load the result as the item finishes; clear reports the old flags
    if (state_nxt == ST_OUT && state_r != ST_OUT) begin
      out_flags_nxt = (kind_r == KIND_CLEAR) ? flags_r : flags_nxt;
      out_addr_nxt  = addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= KIND_WRITE;
      reg_r       <= '0;
      val_r       <= '0;
      flags_r     <= '0;
      addr_r      <= BYTE_W'(DEFAULT_DEV_ADDR);
      out_flags_r <= '0;
      out_addr_r  <= '0;
      out_rst_r   <= 1'b0;
      out_ers_r   <= 1'b0;
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_r[i] <= cfg_reset_val(CFG_IDX_W'(i));
      end
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      reg_r       <= reg_nxt;
      val_r       <= val_nxt;
      flags_r     <= flags_nxt;
      addr_r      <= addr_nxt;
      out_flags_r <= out_flags_nxt;
      out_addr_r  <= out_addr_nxt;
      out_rst_r   <= out_rst_nxt;
      out_ers_r   <= out_ers_nxt;
      if (cfg_valid) begin
        cfg_r[cfg_index] <= cfg_data;
      end
    end
  end

endmodule
